>>> src/tpes_pkg.sv
// Shared types, constants and the event-window helper for the timeline sequencer.
// No dependencies; imported by every module of the block.
package tpes_pkg;

	localparam int DEF_EVENT_SLOTS = 16;
	localparam int QDEPTH = 4;
	localparam int DIV_W = 41;

	typedef logic [3:0] op_t;
	localparam op_t OP_TICK       = 4'd0;
	localparam op_t OP_PLAY       = 4'd1;
	localparam op_t OP_PLAY_START = 4'd2;
	localparam op_t OP_REVERSE    = 4'd3;
	localparam op_t OP_REV_END    = 4'd4;
	localparam op_t OP_STOP       = 4'd5;
	localparam op_t OP_SET_POS    = 4'd6;
	localparam op_t OP_SET_CLAMP  = 4'd7;
	localparam op_t OP_WRITE_EV   = 4'd8;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_SCAN  = 2'd0;
	localparam cmd_t CMD_WRITE = 2'd1;
	localparam cmd_t CMD_STAT  = 2'd2;

	typedef struct packed {
		logic [31:0] length;
		logic [15:0] rate;
		logic        looping;
	} cfg_t;

	// pos doubles as the event time for CMD_WRITE
	typedef struct packed {
		cmd_t        cmd;
		logic [32:0] lo;
		logic [32:0] hi;
		logic        empty;
		logic [31:0] pos;
		logic        playing;
		logic        reversing;
		logic        fin;
		logic [3:0]  slot;
		logic        ev_en;
	} qent_t;

	// inclusive [lo,hi] window crossed by a move from old to newp
	function automatic qent_t scan_ent(input logic [31:0] old, input logic [31:0] newp,
			input logic [31:0] len, input logic bw, input logic pl, input logic rv);
		qent_t e;
		logic [32:0] hiex;
		e = '0;
		hiex = '0;
		e.cmd = CMD_SCAN;
		e.pos = newp;
		e.playing = pl;
		e.reversing = rv;
		if (!bw) begin
			hiex = {1'b0, newp} + ((newp == len) ? 33'd1 : 33'd0);
			e.lo = {1'b0, old};
			e.hi = hiex - 33'd1;
			e.empty = (hiex == 33'd0);
		end else begin
			e.lo = (newp == 32'd0) ? 33'd0 : ({1'b0, newp} + 33'd1);
			e.hi = {1'b0, old};
			e.empty = 1'b0;
		end
		return e;
	endfunction

endpackage

>>> src/timeline_playback_event_sequencer.sv
// Timeline playback event sequencer: the input and result channels use valid/stall,
// and an APB-style port holds timeline_length, play_rate and looping at 0x0, 0x4, 0x8.
// An input beat carries a command; each beat yields zero or more event-fired result
// beats (ascending slot order per window), then exactly one status beat with last set.
// Commands enter the front end, which owns position, playing and direction. A tick
// goes through a 32x16 multiply and evaluation; a looping wrap also runs the serial
// remainder unit. Commands then pass through a four-entry queue to the back end,
// which scans the event table one slot per cycle unless it waits on a hit: one pass
// of all slots per window, two windows on a wrap. A new beat is taken once the front
// end has queued the previous one, while the back end still scans. The result
// register holds a beat while result_stall is high; the scan waits on a hit until
// that beat leaves, and a full queue holds the front end. Reset clears position,
// flags, all event valid bits and restores register defaults (length 5.0, rate 1.0,
// no loop).
module timeline_playback_event_sequencer import tpes_pkg::*; #(
	parameter int EVENT_SLOTS = DEF_EVENT_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [3:0]  operation,
	input  logic [31:0] delta_time,
	input  logic [31:0] time_value,
	input  logic        fire_events,
	input  logic [3:0]  event_slot,
	input  logic        event_enable,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [3:0]  fired_event,
	output logic [31:0] position_now,
	output logic        is_playing,
	output logic        is_reversing,
	output logic        finished,
	output logic        last
);
	localparam logic [1:0] REG_LENGTH = 2'd0;
	localparam logic [1:0] REG_RATE   = 2'd1;
	localparam logic [1:0] REG_LOOP   = 2'd2;

	cfg_t  cfg_q;
	logic  wr_en;
	logic  push, pop, q_empty, q_full;
	qent_t push_data, head;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length <= 32'd327680;
			cfg_q.rate <= 16'd256;
			cfg_q.looping <= 1'b0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_LENGTH: cfg_q.length <= pwdata;
				REG_RATE: cfg_q.rate <= pwdata[15:0];
				REG_LOOP: cfg_q.looping <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LENGTH: prdata = cfg_q.length;
			REG_RATE: prdata = {16'd0, cfg_q.rate};
			REG_LOOP: prdata = {31'd0, cfg_q.looping};
			default: prdata = '0;
		endcase
	end

	tpes_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.item_valid(item_valid), .item_stall(item_stall),
		.operation(operation), .delta_time(delta_time), .time_value(time_value),
		.fire_events(fire_events), .event_slot(event_slot), .event_enable(event_enable),
		.q_full(q_full), .push_valid(push), .push_data(push_data)
	);

	tpes_queue #(.DEPTH(QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .head(head), .empty(q_empty), .full(q_full)
	);

	tpes_back #(.EVENT_SLOTS(EVENT_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .head(head), .q_empty(q_empty), .pop(pop),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .fired_event(fired_event), .position_now(position_now),
		.is_playing(is_playing), .is_reversing(is_reversing),
		.finished(finished), .last(last)
	);
endmodule

>>> src/tpes_div.sv
// Restoring remainder unit, one quotient bit per cycle, for loop wraps.
// Depends on tpes_pkg.
module tpes_div import tpes_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [31:0]      divisor,
	output logic             done,
	output logic [31:0]      rem
);
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] num_q;
	logic [31:0]      rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [32:0]      shifted;

	assign shifted = {rem_q, num_q[DIV_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q <= num_q << 1;
			rem_q <= (shifted >= {1'b0, divisor}) ? 32'(shifted - {1'b0, divisor})
				: shifted[31:0];
		end
	end

	assign done = done_q;
	assign rem = rem_q;
endmodule

>>> src/tpes_front.sv
// Front end: accepts beats, owns playback state, computes moves and queues commands.
// Depends on tpes_pkg and tpes_div.
module tpes_front import tpes_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [3:0]  operation,
	input  logic [31:0] delta_time,
	input  logic [31:0] time_value,
	input  logic        fire_events,
	input  logic [3:0]  event_slot,
	input  logic        event_enable,
	input  logic        q_full,
	output logic        push_valid,
	output qent_t       push_data
);
	typedef enum logic [6:0] {
		F_IDLE  = 7'b0000001,
		F_DEC   = 7'b0000010,
		F_MUL   = 7'b0000100,
		F_EVAL  = 7'b0001000,
		F_DIV   = 7'b0010000,
		F_FINAL = 7'b0100000,
		F_STAT  = 7'b1000000
	} fstate_t;

	fstate_t     state_q;
	logic [31:0] pos_q, np_q;
	logic        playing_q, bw_q, fin_q, dir_q;
	op_t         op_q;
	logic [31:0] delta_q, tv_q;
	logic        fire_q, en_q;
	logic [3:0]  slot_q;
	logic [47:0] prod_q;

	logic [15:0] ar;
	logic        neg, fwd, over_f, over_b, eval_loop;
	logic [39:0] mag;
	logic [40:0] sum41;
	logic        div_start, div_done;
	logic [DIV_W-1:0] div_num;
	logic [31:0] div_rem;

	assign ar = cfg.rate[15] ? 16'(~cfg.rate + 16'd1) : cfg.rate;
	assign neg = cfg.rate[15] ^ bw_q;
	assign mag = prod_q[47:8];
	assign sum41 = {9'b0, pos_q} + {1'b0, mag};
	assign fwd = (mag != '0) && !neg;
	assign over_f = fwd && (sum41 > {9'b0, cfg.length});
	assign over_b = neg && (mag > {8'b0, pos_q});
	assign eval_loop = (over_f || over_b) && cfg.looping;
	assign div_start = (state_q == F_EVAL) && eval_loop && !q_full && (cfg.length != '0);
	assign div_num = over_f ? (sum41 - 41'd1) : {1'b0, 40'(mag - {8'b0, pos_q})};
	assign item_stall = (state_q != F_IDLE);

	tpes_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(cfg.length), .done(div_done), .rem(div_rem)
	);

	always_comb begin
		push_valid = 1'b0;
		push_data = '0;
		case (state_q)
			F_DEC: begin
				push_valid = (op_q == OP_WRITE_EV) && !q_full;
				push_data.cmd = CMD_WRITE;
				push_data.pos = tv_q;
				push_data.slot = slot_q;
				push_data.ev_en = en_q;
			end
			F_EVAL: begin
				push_valid = eval_loop && !q_full;
				push_data = over_f
					? scan_ent(pos_q, cfg.length, cfg.length, bw_q, playing_q, playing_q & bw_q)
					: scan_ent(pos_q, 32'd0, cfg.length, bw_q, playing_q, playing_q & bw_q);
			end
			F_FINAL: begin
				push_valid = !q_full;
				push_data = scan_ent(pos_q, np_q, cfg.length, bw_q, playing_q,
					playing_q & bw_q);
			end
			F_STAT: begin
				push_valid = !q_full;
				push_data.cmd = CMD_STAT;
				push_data.pos = pos_q;
				push_data.playing = playing_q;
				push_data.reversing = playing_q & bw_q;
				push_data.fin = fin_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pos_q <= '0;
			playing_q <= 1'b0;
			bw_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: if (item_valid) state_q <= F_DEC;
				F_DEC: begin
					fin_q <= 1'b0;
					state_q <= F_STAT;
					case (op_q)
						OP_TICK: if (playing_q) state_q <= F_MUL;
						OP_PLAY: begin bw_q <= 1'b0; playing_q <= 1'b1; end
						OP_PLAY_START: begin
							pos_q <= '0; bw_q <= 1'b0; playing_q <= 1'b1;
						end
						OP_REVERSE: begin bw_q <= 1'b1; playing_q <= 1'b1; end
						OP_REV_END: begin
							pos_q <= cfg.length; bw_q <= 1'b1; playing_q <= 1'b1;
						end
						OP_STOP: playing_q <= 1'b0;
						OP_SET_POS: begin
							if (fire_q) begin
								np_q <= tv_q;
								state_q <= F_FINAL;
							end else begin
								pos_q <= tv_q;
							end
						end
						OP_SET_CLAMP: pos_q <= (tv_q > cfg.length) ? cfg.length : tv_q;
						OP_WRITE_EV: if (q_full) state_q <= F_DEC;
						default: ;
					endcase
				end
				F_MUL: state_q <= F_EVAL;
				F_EVAL: begin
					if (eval_loop) begin
						if (!q_full) begin
							dir_q <= over_b;
							pos_q <= over_f ? 32'd0 : cfg.length;
							if (cfg.length == '0) begin
								np_q <= '0;
								state_q <= F_FINAL;
							end else begin
								state_q <= F_DIV;
							end
						end
					end else if (over_f) begin
						np_q <= cfg.length;
						playing_q <= 1'b0;
						fin_q <= 1'b1;
						state_q <= F_FINAL;
					end else if (over_b) begin
						np_q <= '0;
						playing_q <= 1'b0;
						fin_q <= 1'b1;
						state_q <= F_FINAL;
					end else begin
						np_q <= neg ? (pos_q - mag[31:0]) : (fwd ? sum41[31:0] : pos_q);
						state_q <= F_FINAL;
					end
				end
				F_DIV: begin
					if (div_done) begin
						if (dir_q)
							np_q <= (div_rem == '0) ? 32'd0 : (cfg.length - div_rem);
						else
							np_q <= div_rem + 32'd1;
						state_q <= F_FINAL;
					end
				end
				F_FINAL: begin
					if (!q_full) begin
						pos_q <= np_q;
						state_q <= F_STAT;
					end
				end
				F_STAT: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && item_valid) begin
			op_q <= operation;
			delta_q <= delta_time;
			tv_q <= time_value;
			fire_q <= fire_events;
			slot_q <= event_slot;
			en_q <= event_enable;
		end
		if (state_q == F_MUL)
			prod_q <= 48'(delta_q) * 48'(ar);
	end

	a_div_to_final: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV) && div_done |=> (state_q == F_FINAL))
		else $error("divider result not consumed");
endmodule

>>> src/tpes_queue.sv
// Command queue between front and back ends.
// Depends on tpes_pkg.
module tpes_queue import tpes_pkg::*; #(
	parameter int DEPTH = QDEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  qent_t push_data,
	input  logic  pop,
	output qent_t head,
	output logic  empty,
	output logic  full
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qent_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == CW'(DEPTH));
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue pop while empty");
endmodule

>>> src/tpes_back.sv
// Back end: owns the event table, scans windows one slot per cycle unless held on a hit, drives result beats.
// Depends on tpes_pkg.
module tpes_back import tpes_pkg::*; #(
	parameter int EVENT_SLOTS = DEF_EVENT_SLOTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qent_t       head,
	input  logic        q_empty,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        kind,
	output logic [3:0]  fired_event,
	output logic [31:0] position_now,
	output logic        is_playing,
	output logic        is_reversing,
	output logic        finished,
	output logic        last
);
	localparam int IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

	logic [31:0]            times_q [EVENT_SLOTS];
	logic [EVENT_SLOTS-1:0] valid_q;
	logic [IW-1:0]          idx_q;
	logic                   rv_q;
	logic                   emit_ok, hit, is_scan, is_stat, is_write, load, scan_adv;
	logic [32:0]            t33;

	assign emit_ok = !rv_q || !result_stall;
	assign is_scan = !q_empty && (head.cmd == CMD_SCAN);
	assign is_stat = !q_empty && (head.cmd == CMD_STAT);
	assign is_write = !q_empty && (head.cmd == CMD_WRITE);
	assign t33 = {1'b0, times_q[idx_q]};
	assign hit = valid_q[idx_q] && !head.empty && (t33 >= head.lo) && (t33 <= head.hi);
	assign scan_adv = is_scan && (!hit || emit_ok);
	assign load = (is_scan && hit && emit_ok) || (is_stat && emit_ok);
	assign pop = (scan_adv && (idx_q == IW'(EVENT_SLOTS - 1))) || (is_stat && emit_ok)
		|| is_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			idx_q <= '0;
			rv_q <= 1'b0;
		end else begin
			if (is_write && (32'(head.slot) < EVENT_SLOTS))
				valid_q[IW'(head.slot)] <= head.ev_en;
			if (scan_adv)
				idx_q <= (idx_q == IW'(EVENT_SLOTS - 1)) ? '0 : idx_q + 1'b1;
			if (load)
				rv_q <= 1'b1;
			else if (!result_stall)
				rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_write && (32'(head.slot) < EVENT_SLOTS))
			times_q[IW'(head.slot)] <= head.pos;
		if (load) begin
			kind <= is_stat;
			fired_event <= is_stat ? 4'd0 : 4'(idx_q);
			position_now <= head.pos;
			is_playing <= head.playing;
			is_reversing <= head.reversing;
			finished <= is_stat & head.fin;
			last <= is_stat;
		end
	end

	assign result_valid = rv_q;

	a_idx_rests: assert property (@(posedge clk) disable iff (!arst_n)
		!is_scan |=> (idx_q == '0) || is_scan)
		else $error("scan index left mid-table");
endmodule

>>> verif/timeline_playback_event_sequencer_tb.sv
// Self-checking testbench for the timeline playback event sequencer: directed and random
// command beats, APB register writes between phases, a local playback predictor per beat.
// Depends on tpes_pkg and the timeline_playback_event_sequencer RTL.
module timeline_playback_event_sequencer_tb;
	import tpes_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic        kind;
		logic [3:0]  fired_event;
		logic [31:0] position_now;
		logic        is_playing;
		logic        is_reversing;
		logic        finished;
		logic        last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [3:0] operation = '0;
	logic [31:0] delta_time = '0, time_value = '0;
	logic fire_events = 1'b0, event_slot_en = 1'b0;
	logic [3:0] event_slot = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic kind, is_playing, is_reversing, finished, last;
	logic [3:0] fired_event;
	logic [31:0] position_now;

	timeline_playback_event_sequencer dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall), .operation(operation),
		.delta_time(delta_time), .time_value(time_value), .fire_events(fire_events),
		.event_slot(event_slot), .event_enable(event_slot_en),
		.result_valid(result_valid), .result_stall(result_stall), .kind(kind),
		.fired_event(fired_event), .position_now(position_now), .is_playing(is_playing),
		.is_reversing(is_reversing), .finished(finished), .last(last)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [31:0] cfg_length = 32'd327680;
	logic [15:0] cfg_rate = 16'd256;
	logic        cfg_loop = 1'b0;
	logic [31:0] play_pos;
	logic        play_on, play_bw;
	logic [31:0] ev_time [16];
	logic        ev_on [16];

	res_t expected_results[$];
	int errors = 0;
	int beats_sent = 0, results_seen = 0, events_seen = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	int quiet_cycles = 0;

	task automatic push_result(input logic k, input logic [3:0] idx, input logic fin);
		res_t r;
		r.kind = k;
		r.fired_event = idx;
		r.position_now = play_pos;
		r.is_playing = play_on;
		r.is_reversing = play_on & play_bw;
		r.finished = fin;
		r.last = k;
		expected_results.push_back(r);
	endtask

	task automatic move_pos(input logic [31:0] newp, input logic fire);
		logic [31:0] old;
		logic [32:0] hi;
		logic hit;
		old = play_pos;
		play_pos = newp;
		if (fire) begin
			for (int i = 0; i < 16; i++) begin
				if (ev_on[i]) begin
					if (!play_bw) begin
						hi = {1'b0, newp} + ((newp == cfg_length) ? 33'd1 : 33'd0);
						hit = (ev_time[i] >= old) && ({1'b0, ev_time[i]} < hi);
					end else begin
						hit = ((newp == 0) || (ev_time[i] > newp)) && (ev_time[i] <= old);
					end
					if (hit)
						push_result(1'b0, 4'(i), 1'b0);
				end
			end
		end
	endtask

	task automatic predict_tick(input logic [31:0] delta, output logic fin);
		logic [15:0] arate;
		logic neg;
		logic [63:0] mag, np, m;
		fin = 1'b0;
		arate = cfg_rate[15] ? 16'(-cfg_rate) : cfg_rate;
		neg = cfg_rate[15] != play_bw;
		mag = (64'(delta) * 64'(arate)) >> 8;
		if (mag > 0 && !neg) begin
			np = 64'(play_pos) + mag;
			if (np > 64'(cfg_length)) begin
				if (cfg_loop) begin
					move_pos(cfg_length, 1'b1);
					move_pos(32'd0, 1'b0);
					np = (cfg_length > 0) ? ((np - 1) % 64'(cfg_length)) + 1 : 64'd0;
				end else begin
					np = 64'(cfg_length);
					play_on = 1'b0;
					fin = 1'b1;
				end
			end
		end else if (neg && mag > 64'(play_pos)) begin
			if (cfg_loop) begin
				m = mag - 64'(play_pos);
				move_pos(32'd0, 1'b1);
				move_pos(cfg_length, 1'b0);
				if (cfg_length > 0)
					np = (m % 64'(cfg_length) == 0) ? 64'd0
						: 64'(cfg_length) - (m % 64'(cfg_length));
				else
					np = 64'd0;
			end else begin
				np = 64'd0;
				play_on = 1'b0;
				fin = 1'b1;
			end
		end else begin
			np = 64'(play_pos) - (neg ? mag : 64'd0);
		end
		move_pos(np[31:0], 1'b1);
	endtask

	task automatic predict_command(input logic [3:0] op, input logic [31:0] dt,
			input logic [31:0] tv, input logic fe, input logic [3:0] slot, input logic en);
		logic fin;
		fin = 1'b0;
		case (op)
			OP_TICK: if (play_on) predict_tick(dt, fin);
			OP_PLAY: begin
				play_bw = 1'b0;
				play_on = 1'b1;
			end
			OP_PLAY_START: begin
				move_pos(32'd0, 1'b0);
				play_bw = 1'b0;
				play_on = 1'b1;
			end
			OP_REVERSE: begin
				play_bw = 1'b1;
				play_on = 1'b1;
			end
			OP_REV_END: begin
				move_pos(cfg_length, 1'b0);
				play_bw = 1'b1;
				play_on = 1'b1;
			end
			OP_STOP: play_on = 1'b0;
			OP_SET_POS: move_pos(tv, fe);
			OP_SET_CLAMP: move_pos((tv > cfg_length) ? cfg_length : tv, 1'b0);
			OP_WRITE_EV: begin
				ev_time[slot] = tv;
				ev_on[slot] = en;
			end
			default: ;
		endcase
		push_result(1'b1, 4'd0, fin);
	endtask

	task automatic send_command(input logic [3:0] op, input logic [31:0] dt,
			input logic [31:0] tv, input logic fe, input logic [3:0] slot, input logic en);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		predict_command(op, dt, tv, fe, slot, en);
		item_valid <= 1'b1;
		operation <= op;
		delta_time <= dt;
		time_value <= tv;
		fire_events <= fe;
		event_slot <= slot;
		event_slot_en <= en;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		item_valid <= 1'b0;
		beats_sent++;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] len, input logic [15:0] rate, input logic lp);
		drain();
		write_reg(4'h0, len);
		write_reg(4'h4, {16'd0, rate});
		write_reg(4'h8, {31'd0, lp});
		cfg_length = len;
		cfg_rate = rate;
		cfg_loop = lp;
	endtask

	// result checker
	always @(posedge clk) begin
		res_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (!kind)
					events_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat kind=%0d ev=%0d pos=%h", $time,
						kind, fired_event, position_now);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (kind !== e.kind || fired_event !== e.fired_event ||
							position_now !== e.position_now || is_playing !== e.is_playing ||
							is_reversing !== e.is_reversing || finished !== e.finished ||
							last !== e.last) begin
						$display("%0t: mismatch expected k=%0d ev=%0d pos=%h pl=%0d rv=%0d fin=%0d last=%0d",
							$time, e.kind, e.fired_event, e.position_now, e.is_playing,
							e.is_reversing, e.finished, e.last);
						$display("%0t:          actual   k=%0d ev=%0d pos=%h pl=%0d rv=%0d fin=%0d last=%0d",
							$time, kind, fired_event, position_now, is_playing, is_reversing,
							finished, last);
						errors++;
					end
				end
			end
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				expected_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_time();
		case ($urandom_range(3))
			0: return $urandom_range(cfg_length);
			1: return cfg_length;
			2: return 32'd0;
			default: return $urandom();
		endcase
	endfunction

	task automatic test_directed;
		send_command(OP_WRITE_EV, 32'd0, 32'd0, 1'b0, 4'd0, 1'b1);
		send_command(OP_WRITE_EV, 32'd0, 32'h0001_0000, 1'b0, 4'd1, 1'b1);
		send_command(OP_WRITE_EV, 32'd0, 32'd327680, 1'b0, 4'd15, 1'b1);
		send_command(OP_WRITE_EV, 32'd0, 32'hFFFF_FFFF, 1'b0, 4'd7, 1'b1);
		send_command(OP_WRITE_EV, 32'd0, 32'h0002_0000, 1'b0, 4'd8, 1'b0);
		send_command(OP_TICK, 32'h0001_0000, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_PLAY, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'h0000_0000, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'h0002_0000, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_PLAY_START, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_REV_END, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'h0001_8000, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'h0010_0000, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_REVERSE, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_STOP, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_SET_POS, 32'd0, 32'h0004_0000, 1'b1, 4'd0, 1'b0);
		send_command(OP_SET_POS, 32'd0, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0);
		send_command(OP_SET_CLAMP, 32'd0, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0);
		send_command(OP_SET_CLAMP, 32'd0, 32'h0000_8000, 1'b0, 4'd0, 1'b0);
		send_command(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 4'hF, 1'b1);
		send_command(4'd15, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
	endtask

	task automatic test_loop_wrap;
		configure(32'h0001_0000, 16'h0100, 1'b1);
		send_command(OP_PLAY_START, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'h0003_4000, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_REVERSE, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'h0005_0000, 32'd0, 1'b0, 4'd0, 1'b0);
		configure(32'd0, 16'h8000, 1'b1);
		send_command(OP_PLAY, 32'd0, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'hFFFF_FFFF, 32'd0, 1'b0, 4'd0, 1'b0);
		send_command(OP_TICK, 32'd1, 32'd0, 1'b0, 4'd0, 1'b0);
	endtask

	task automatic test_random(input int count);
		logic [3:0] op;
		logic [31:0] dt;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8: op = OP_TICK;
				9: op = OP_PLAY;
				10: op = OP_PLAY_START;
				11: op = OP_REVERSE;
				12: op = OP_REV_END;
				13: op = OP_STOP;
				14, 15: op = OP_SET_POS;
				16: op = OP_SET_CLAMP;
				17, 18: op = OP_WRITE_EV;
				default: op = 4'($urandom_range(15));
			endcase
			dt = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(32'h0002_0000);
			send_command(op, dt, rand_time(), 1'($urandom()), 4'($urandom()),
				1'($urandom_range(3) != 0));
		end
	endtask

	task automatic test_random_phases;
		send_idle_pct = 34;
		recv_idle_pct = 60;
		configure(32'h0003_0000, 16'h0180, 1'b1);
		test_random(70);
		drain();
		send_idle_pct = 60;
		recv_idle_pct = 34;
		configure(32'hFFFF_FFFF, 16'h7FFF, 1'b0);
		test_random(20);
		configure(32'h0002_0000, 16'hFF00, 1'b1);
		test_random(50);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(32'h0004_0000, 16'h0040, 1'b0);
		test_random(60);
	endtask

	initial begin
		for (int i = 0; i < 16; i++) begin
			ev_time[i] = '0;
			ev_on[i] = 1'b0;
		end
		play_pos = '0;
		play_on = 1'b0;
		play_bw = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_loop_wrap();
		test_random_phases();
		drain();
		$display("Covered %0d command beats, %0d result beats (%0d events fired),", beats_sent,
			results_seen, events_seen);
		$display("under stall/idle mixes and length, rate and loop settings incl. extremes.");
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
src/tpes_pkg.sv
src/tpes_div.sv
src/tpes_front.sv
src/tpes_queue.sv
src/tpes_back.sv
src/timeline_playback_event_sequencer.sv
verif/timeline_playback_event_sequencer_tb.sv
